// ----- sv/multi_token_bucket_with_daily_quota_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the token bucket limiter
// Each macro expands to one labelled concurrent assertion on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_TOKEN_BUCKET_WITH_DAILY_QUOTA_DEFINES_SVH
`define MULTI_TOKEN_BUCKET_WITH_DAILY_QUOTA_DEFINES_SVH

// same-cycle implication
`define MTB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MTB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/mtb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtb_pkg
// Types, codes and constants shared by the token bucket limiter.
// ----------------------------------------------------------------------------
package mtb_pkg;

	localparam int NUM_BUCKETS_DEF = 16;
	localparam int TOKEN_FRAC_BITS = 24;
	localparam int DIV_W           = 48;
	localparam int Q_DEPTH         = 2;

	localparam logic [47:0] M48       = 48'hFFFF_FFFF_FFFF;
	localparam logic [39:0] TPD_RESET = 40'd86400000000;
	localparam logic [39:0] PHS_RESET = 40'd0;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_CFG   = 2'd1;
	localparam logic [1:0] CMD_ACQ   = 2'd2;
	localparam logic [1:0] CMD_PROBE = 2'd3;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_SHORT = 3'd1;
	localparam logic [2:0] ST_QUOTA = 3'd2;
	localparam logic [2:0] ST_BAD   = 3'd3;
	localparam logic [2:0] ST_NREG  = 3'd4;

	localparam logic REG_TPD   = 1'b0;
	localparam logic REG_PHASE = 1'b1;

	// front-end classification of a word
	localparam logic [2:0] CL_TICK  = 3'd0;
	localparam logic [2:0] CL_BAD   = 3'd1;
	localparam logic [2:0] CL_NREG  = 3'd2;
	localparam logic [2:0] CL_CFG   = 3'd3;
	localparam logic [2:0] CL_ACQ   = 3'd4;
	localparam logic [2:0] CL_PROBE = 3'd5;

	typedef struct packed {
		logic [2:0]  cls;
		logic [3:0]  idx;
		logic [47:0] cost;
		logic [47:0] cap;
		logic [31:0] rate;
		logic [31:0] quota;
		logic [15:0] tk;
	} item_t;

	typedef struct packed {
		logic [47:0] tokens;
		logic [47:0] last;
		logic [47:0] cap;
		logic [31:0] rate;
		logic [31:0] quota;
		logic [31:0] left;
		logic [47:0] deadline;
	} bucket_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] num;
		logic [DIV_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quo;
		logic [DIV_W-1:0] rem;
	} div_rsp_t;

endpackage

// ----- sv/mtb_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtb_front
// Accepts command words, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module mtb_front import mtb_pkg::*; #(
	parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic [3:0]         bucket_index,
	input  logic [47:0]        cost,
	input  logic [47:0]        capacity,
	input  logic [31:0]        refill_rate,
	input  logic signed [31:0] request_quota,
	input  logic [15:0]        tick_count,
	output logic               q_valid,
	output item_t              q_item,
	input  logic               q_pop
);

	localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CW = $clog2(Q_DEPTH + 1);
	localparam logic [8:0] NB = 9'(NUM_BUCKETS);

	item_t          fifo_q [Q_DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	item_t          cls_item;
	logic           push;

	always_comb begin
		cls_item.idx   = bucket_index;
		cls_item.cost  = cost;
		cls_item.cap   = capacity;
		cls_item.rate  = refill_rate;
		cls_item.quota = request_quota;
		cls_item.tk    = tick_count;
		case (command)
			CMD_TICK:  cls_item.cls = CL_TICK;
			CMD_CFG:   cls_item.cls = (capacity == '0 || refill_rate == '0) ? CL_BAD : CL_CFG;
			CMD_ACQ:   cls_item.cls = (cost == '0) ? CL_BAD : CL_ACQ;
			CMD_PROBE: cls_item.cls = CL_PROBE;
			default:   cls_item.cls = CL_TICK;
		endcase
		// out-of-range index only matters once the argument check has passed
		if (cls_item.cls != CL_TICK && cls_item.cls != CL_BAD && {5'd0, bucket_index} >= NB)
			cls_item.cls = CL_NREG;
	end

	assign in_ready = (cnt_q != CW'(Q_DEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != '0);
	assign q_item   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				fifo_q[wr_ptr_q] <= cls_item;
				wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !q_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!push && q_pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ----- sv/mtb_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtb_div
// Restoring divider, one quotient bit per cycle; gives quotient and remainder.
// ----------------------------------------------------------------------------
module mtb_div import mtb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int NW = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] rem_q, quo_q, den_q;
	logic [NW-1:0]    cnt_q;
	logic             busy_q, done_q;
	logic [DIV_W:0]   sh;
	logic [DIV_W+1:0] df;
	logic             borrow;

	assign sh     = {rem_q, quo_q[DIV_W-1]};
	assign df     = {1'b0, sh} - {2'b00, den_q};
	assign borrow = df[DIV_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				rem_q  <= '0;
				quo_q  <= req.num;
				den_q  <= req.den;
				cnt_q  <= NW'(DIV_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= borrow ? sh[DIV_W-1:0] : df[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], ~borrow};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == NW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

// ----- sv/mtb_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtb_back
// Executes queued words: time keeping, bucket table, refill and result register.
// ----------------------------------------------------------------------------
module mtb_back import mtb_pkg::*; #(
	parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [39:0]        cfg_data,
	input  logic               q_valid,
	input  item_t              q_item,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic [47:0]        wait_ticks,
	output logic [47:0]        tokens_now,
	output logic signed [31:0] daily_left
);

	localparam int IW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_TK1  = 4'd1;
	localparam logic [3:0] S_TK2  = 4'd2;
	localparam logic [3:0] S_RD   = 4'd3;
	localparam logic [3:0] S_DL   = 4'd4;
	localparam logic [3:0] S_MUL0 = 4'd5;
	localparam logic [3:0] S_MUL1 = 4'd6;
	localparam logic [3:0] S_ADD  = 4'd7;
	localparam logic [3:0] S_REF  = 4'd8;
	localparam logic [3:0] S_OP   = 4'd9;
	localparam logic [3:0] S_PDIV = 4'd10;
	localparam logic [3:0] S_WB   = 4'd11;

	bucket_t mem [NUM_BUCKETS];
	bucket_t rd_q, w_q;
	logic [NUM_BUCKETS-1:0] valid_q;

	logic [3:0]  state_q;
	item_t       cur_q;
	logic [47:0] time_q;
	logic [39:0] phase_q;
	logic [39:0] tpd_q;
	logic [39:0] len;
	logic [IW-1:0] raddr, addr;
	logic        mem_we;

	logic        div_start_q;
	logic [47:0] div_num_q, div_den_q;
	div_req_t    dreq;
	div_rsp_t    drsp;

	logic [55:0] p_lo_s1, p_hi_s1;
	logic [47:0] add_q;
	logic [47:0] el;
	logic [79:0] full;
	logic [48:0] tok_sum;
	logic [48:0] tk_sum;
	logic [48:0] t_ext;
	logic [40:0] to_midnight;
	logic [48:0] dl_sum;
	logic [48:0] ph_sum;
	logic [47:0] deficit;

	logic        ovalid_q;
	logic [2:0]  status_q;
	logic [47:0] wait_q, tok_q;
	logic [31:0] left_q;

	assign len     = (tpd_q == '0) ? 40'd1 : tpd_q;
	assign raddr   = IW'(q_item.idx);
	assign addr    = IW'(cur_q.idx);
	assign q_pop   = (state_q == S_IDLE) && q_valid && !ovalid_q;
	assign mem_we  = (state_q == S_WB);

	assign el      = time_q - w_q.last;
	assign full    = {p_hi_s1, 24'd0} + {24'd0, p_lo_s1};
	assign tok_sum = {1'b0, w_q.tokens} + {1'b0, add_q};
	assign tk_sum  = {1'b0, time_q} + {33'd0, q_item.tk};
	assign t_ext   = {1'b0, time_q};
	assign to_midnight = {1'b0, len} - {1'b0, drsp.rem[39:0]};
	assign dl_sum  = t_ext + {8'd0, to_midnight};
	assign ph_sum  = {1'b0, drsp.rem} + {33'd0, cur_q.tk};
	assign deficit = cur_q.cost - w_q.tokens;

	assign dreq.start = div_start_q;
	assign dreq.num   = div_num_q;
	assign dreq.den   = div_den_q;

	mtb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// bucket table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[addr] <= w_q;
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			time_q      <= '0;
			phase_q     <= PHS_RESET;
			tpd_q       <= TPD_RESET;
			div_start_q <= 1'b0;
			ovalid_q    <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (ovalid_q && out_ready)
				ovalid_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == REG_TPD)
					tpd_q <= cfg_data;
				else
					phase_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						cur_q <= q_item;
						case (q_item.cls)
							CL_TICK: begin
								time_q      <= tk_sum[48] ? M48 : tk_sum[47:0];
								div_num_q   <= {8'd0, phase_q};
								div_den_q   <= {8'd0, len};
								div_start_q <= 1'b1;
								state_q     <= S_TK1;
							end
							CL_BAD, CL_NREG: begin
								status_q <= (q_item.cls == CL_BAD) ? ST_BAD : ST_NREG;
								wait_q   <= '0;
								tok_q    <= '0;
								left_q   <= '0;
								ovalid_q <= 1'b1;
							end
							default: state_q <= S_RD;
						endcase
					end
				end
				S_TK1: begin
					if (drsp.done) begin
						div_num_q   <= ph_sum[47:0];
						div_den_q   <= {8'd0, len};
						div_start_q <= 1'b1;
						state_q     <= S_TK2;
					end
				end
				S_TK2: begin
					if (drsp.done) begin
						phase_q  <= drsp.rem[39:0];
						status_q <= ST_OK;
						wait_q   <= '0;
						tok_q    <= '0;
						left_q   <= '0;
						ovalid_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_RD: begin
					div_num_q <= {8'd0, phase_q};
					div_den_q <= {8'd0, len};
					if (cur_q.cls == CL_CFG) begin
						w_q.tokens  <= cur_q.cap;
						w_q.last    <= time_q;
						w_q.cap     <= cur_q.cap;
						w_q.rate    <= cur_q.rate;
						w_q.quota   <= cur_q.quota;
						w_q.left    <= cur_q.quota;
						w_q.deadline <= rd_q.deadline;
						div_start_q <= 1'b1;
						state_q     <= S_DL;
					end else if (!valid_q[addr]) begin
						status_q <= ST_NREG;
						wait_q   <= '0;
						tok_q    <= '0;
						left_q   <= '0;
						ovalid_q <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						w_q <= rd_q;
						// day rolled over: restore quota, new deadline
						if (time_q > rd_q.deadline) begin
							w_q.left    <= rd_q.quota;
							div_start_q <= 1'b1;
							state_q     <= S_DL;
						end else begin
							state_q <= S_MUL0;
						end
					end
				end
				S_DL: begin
					if (drsp.done) begin
						w_q.deadline <= dl_sum[48] ? M48 : dl_sum[47:0];
						if (cur_q.cls == CL_CFG) begin
							status_q <= ST_OK;
							wait_q   <= '0;
							state_q  <= S_WB;
						end else begin
							state_q <= S_MUL0;
						end
					end
				end
				S_MUL0: begin
					p_lo_s1 <= el[23:0] * w_q.rate;
					state_q <= (time_q <= w_q.last) ? S_OP : S_MUL1;
				end
				S_MUL1: begin
					p_hi_s1 <= el[47:24] * w_q.rate;
					state_q <= S_ADD;
				end
				S_ADD: begin
					add_q   <= (full[79:48] != '0) ? M48 : full[47:0];
					state_q <= S_REF;
				end
				S_REF: begin
					if (add_q >= w_q.cap || tok_sum >= {1'b0, w_q.cap})
						w_q.tokens <= w_q.cap;
					else
						w_q.tokens <= tok_sum[47:0];
					w_q.last <= time_q;
					state_q  <= S_OP;
				end
				S_OP: begin
					wait_q  <= '0;
					state_q <= S_WB;
					if (cur_q.cls == CL_ACQ) begin
						if (w_q.left == '0)
							status_q <= ST_QUOTA;
						else if (w_q.tokens < cur_q.cost)
							status_q <= ST_SHORT;
						else begin
							status_q   <= ST_OK;
							w_q.tokens <= w_q.tokens - cur_q.cost;
							if (!w_q.left[31])
								w_q.left <= w_q.left - 1'b1;
						end
					end else if (w_q.left == '0) begin
						status_q <= ST_QUOTA;
						if (cur_q.cost != '0 && w_q.deadline > time_q)
							wait_q <= w_q.deadline - time_q;
					end else if (cur_q.cost != '0 && w_q.tokens < cur_q.cost) begin
						status_q <= ST_SHORT;
						if (w_q.rate == '0) begin
							wait_q <= M48;
						end else begin
							div_num_q   <= deficit;
							div_den_q   <= {16'd0, w_q.rate};
							div_start_q <= 1'b1;
							state_q     <= S_PDIV;
						end
					end else begin
						status_q <= ST_OK;
					end
				end
				S_PDIV: begin
					if (drsp.done) begin
						// round the wait up
						wait_q  <= drsp.quo + {47'd0, (drsp.rem != '0)};
						state_q <= S_WB;
					end
				end
				S_WB: begin
					valid_q[addr] <= 1'b1;
					tok_q    <= w_q.tokens;
					left_q   <= w_q.left;
					ovalid_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = ovalid_q;
	assign status     = status_q;
	assign wait_ticks = wait_q;
	assign tokens_now = tok_q;
	assign daily_left = left_q;

endmodule

// ----- sv/multi_token_bucket_with_daily_quota.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_token_bucket_with_daily_quota
// Token bucket limiter with a daily request quota over a table of buckets.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  in       | in_valid / in_ready  | command, bucket_index, cost, capacity,
//           |                      | refill_rate, request_quota, tick_count
//  out      | out_valid / out_ready| status, wait_ticks, tokens_now, daily_left
//  cfg      | cfg_we               | cfg_index, cfg_data
//
//  Bad argument or index out of range: answered from idle; unregistered bucket:
//  after the table read; acquire or probe: read, refill, operate (no refill if
//  no tick since the last refill); tick: two serial divider passes for the day
//  phase; configure: one; day rollover or probe short of tokens adds one each.
//  The serial divider sets the pace. Reset clears valid bits at once, no sweep.
//  A two-word queue lets input be taken while a result waits on out_ready.
// ----------------------------------------------------------------------------
module multi_token_bucket_with_daily_quota import mtb_pkg::*; #(
	parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [39:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic [3:0]         bucket_index,
	input  logic [47:0]        cost,
	input  logic [47:0]        capacity,
	input  logic [31:0]        refill_rate,
	input  logic signed [31:0] request_quota,
	input  logic [15:0]        tick_count,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic [47:0]        wait_ticks,
	output logic [47:0]        tokens_now,
	output logic signed [31:0] daily_left
);

	logic  q_valid, q_pop;
	item_t q_item;

	mtb_front #(.NUM_BUCKETS(NUM_BUCKETS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.bucket_index  (bucket_index),
		.cost          (cost),
		.capacity      (capacity),
		.refill_rate   (refill_rate),
		.request_quota (request_quota),
		.tick_count    (tick_count),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	mtb_back #(.NUM_BUCKETS(NUM_BUCKETS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.wait_ticks (wait_ticks),
		.tokens_now (tokens_now),
		.daily_left (daily_left)
	);

endmodule

// ----- sv/mtb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtb_checker
// Port-level checks on the input and result channels of the limiter.
// ----------------------------------------------------------------------------
`include "multi_token_bucket_with_daily_quota_defines.svh"

module mtb_checker import mtb_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [2:0]         status,
	input logic [47:0]        wait_ticks,
	input logic [47:0]        tokens_now,
	input logic signed [31:0] daily_left
);

	logic         out_stall;
	logic [130:0] out_word;
	logic         err_res;
	logic         no_data;

	assign out_stall = out_valid && !out_ready;
	assign out_word  = {status, wait_ticks, tokens_now, daily_left};
	assign err_res   = out_valid && (status == ST_BAD || status == ST_NREG);
	assign no_data   = (wait_ticks == '0) && (tokens_now == '0) && (daily_left == '0);

	`MTB_ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(out_word), "result word changed while stalled")
	`MTB_ASSERT_IMP(a_err_zero, err_res, no_data, "error result carries data")
	`MTB_ASSERT_IMP(a_ok_nowait, out_valid && status == ST_OK, wait_ticks == '0, "granted result shows a wait")
	`MTB_ASSERT_NXT(a_in_hold, in_valid && !in_ready, in_valid, "input word withdrawn before it was taken")

endmodule

bind multi_token_bucket_with_daily_quota mtb_checker u_mtb_checker (.*);
